[hdl/stwm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stwm_pkg: shared definitions for the sorted two-way merge
// Request codes, list sizing, controller states and the command/status
// structs between controller and datapath.
// ----------------------------------------------------------------------------
package stwm_pkg;

    localparam int LIST_DEPTH = 32;
    localparam int ADDR_W     = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
    localparam int REM_W      = $clog2(2 * LIST_DEPTH + 1);
    localparam int DATA_W     = 32;

    localparam logic [1:0] REQ_PUSH_A = 2'd0;
    localparam logic [1:0] REQ_PUSH_B = 2'd1;
    localparam logic [1:0] REQ_MERGE  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_MERGE
    } state_t;

    typedef struct packed {
        logic push_a;
        logic push_b;
        logic merge_start;
        logic step;
    } cmd_t;

    typedef struct packed {
        logic both_empty;
        logic last_step;
    } status_t;

endpackage

`default_nettype wire

[hdl/stwm_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stwm_ctrl: request decode and merge sequencing
// Decodes accepted requests into datapath commands and holds the block busy
// while a merge streams out.
// ----------------------------------------------------------------------------
module stwm_ctrl
    import stwm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire logic [1:0] req_type,
    input  wire status_t    status,
    output cmd_t            cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        REQ_PUSH_A: cmd.push_a = 1'b1;
                        REQ_PUSH_B: cmd.push_b = 1'b1;
                        REQ_MERGE:
                        begin
                            cmd.merge_start = 1'b1;
                            if (!status.both_empty)
                            begin
                                state_next = ST_MERGE;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MERGE:
            begin
                cmd.step = 1'b1;
                if (status.last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg == ST_MERGE);

endmodule

`default_nettype wire

[hdl/stwm_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stwm_datapath: list stores, head pointers and merge output
// Two list memories with registered reads addressed by the next head
// pointers, a stable two-pointer compare and the result registers.
// ----------------------------------------------------------------------------
module stwm_datapath
    import stwm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cmd_t                     cmd,
    input  wire logic signed [DATA_W-1:0] value,
    output status_t                       status,
    output logic signed [DATA_W-1:0]      merged_value,
    output logic                          from_list_b,
    output logic                          last,
    output logic                          overflow_seen,
    output logic                          result_strobe
);

    logic signed [DATA_W-1:0] mem_a [LIST_DEPTH];
    logic signed [DATA_W-1:0] mem_b [LIST_DEPTH];

    logic signed [DATA_W-1:0] head_a_reg;
    logic signed [DATA_W-1:0] head_b_reg;

    logic [CNT_W-1:0] count_a_reg, count_a_next;
    logic [CNT_W-1:0] count_b_reg, count_b_next;
    logic [CNT_W-1:0] ia_reg, ia_next;
    logic [CNT_W-1:0] ib_reg, ib_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic             ovf_reg, ovf_next;

    logic signed [DATA_W-1:0] merged_value_reg;
    logic                     from_list_b_reg;
    logic                     last_reg;
    logic                     overflow_seen_reg;
    logic                     strobe_reg;

    logic full_a;
    logic full_b;
    logic take_a;
    logic clear_lists;

    assign full_a = (count_a_reg == CNT_W'(LIST_DEPTH));
    assign full_b = (count_b_reg == CNT_W'(LIST_DEPTH));

    assign status.both_empty = (count_a_reg == '0) && (count_b_reg == '0);
    assign status.last_step  = (rem_reg == REM_W'(1));

    assign take_a = (ib_reg >= count_b_reg)
                 || ((ia_reg < count_a_reg) && (head_a_reg <= head_b_reg));

    assign clear_lists = (cmd.merge_start && status.both_empty)
                      || (cmd.step && status.last_step);

    always_comb
    begin
        ia_next      = ia_reg;
        ib_next      = ib_reg;
        rem_next     = rem_reg;
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        ovf_next     = ovf_reg;
        if (cmd.merge_start)
        begin
            ia_next  = '0;
            ib_next  = '0;
            rem_next = REM_W'(count_a_reg) + REM_W'(count_b_reg);
        end
        else if (cmd.step)
        begin
            rem_next = rem_reg - REM_W'(1);
            if (take_a)
            begin
                ia_next = ia_reg + CNT_W'(1);
            end
            else
            begin
                ib_next = ib_reg + CNT_W'(1);
            end
        end
        if (cmd.push_a)
        begin
            if (full_a)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_a_next = count_a_reg + CNT_W'(1);
            end
        end
        if (cmd.push_b)
        begin
            if (full_b)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_b_next = count_b_reg + CNT_W'(1);
            end
        end
        if (clear_lists)
        begin
            count_a_next = '0;
            count_b_next = '0;
            ovf_next     = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_a && !full_a)
        begin
            mem_a[count_a_reg[ADDR_W-1:0]] <= value;
        end
        head_a_reg <= mem_a[ia_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push_b && !full_b)
        begin
            mem_b[count_b_reg[ADDR_W-1:0]] <= value;
        end
        head_b_reg <= mem_b[ib_next[ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg <= '0;
            count_b_reg <= '0;
            ia_reg      <= '0;
            ib_reg      <= '0;
            rem_reg     <= '0;
            ovf_reg     <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            count_a_reg <= count_a_next;
            count_b_reg <= count_b_next;
            ia_reg      <= ia_next;
            ib_reg      <= ib_next;
            rem_reg     <= rem_next;
            ovf_reg     <= ovf_next;
            strobe_reg  <= cmd.step;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            merged_value_reg  <= take_a ? head_a_reg : head_b_reg;
            from_list_b_reg   <= !take_a;
            last_reg          <= status.last_step;
            overflow_seen_reg <= ovf_reg;
        end
    end

    assign merged_value  = merged_value_reg;
    assign from_list_b   = from_list_b_reg;
    assign last          = last_reg;
    assign overflow_seen = overflow_seen_reg;
    assign result_strobe = strobe_reg;

    a_step_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> (rem_reg != '0))
        else $error("merge step with no elements left");

    a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> ((ia_reg <= count_a_reg) && (ib_reg <= count_b_reg)))
        else $error("head pointer past list end");

    a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg) |=> !strobe_reg)
        else $error("transfer after final merge result");

    a_strobe_from_step: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> $past(cmd.step))
        else $error("result transfer without merge step");

endmodule

`default_nettype wire

[hdl/sorted_two_way_merge.sv]
`default_nettype none
// A push is accepted every cycle while busy is low.
// A merge of N stored elements keeps busy high until its last element is stepped out;
// the first result follows the merge state and the result registers, then one per cycle.
// A merge of two empty lists gives no result and leaves busy low.
// Results are strobed for one cycle; the receiver cannot stall.
// Asynchronous active-low reset empties both lists and clears the overflow flag.
// ----------------------------------------------------------------------------
// sorted_two_way_merge: stable two-way merge of two sorted lists
// Loads lists A and B one element per request and on a merge request
// streams all elements in ascending order, A first on ties.
// ----------------------------------------------------------------------------
module sorted_two_way_merge
    import stwm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [1:0]               req_type,
    input  wire logic signed [DATA_W-1:0] value,
    output logic                          result_strobe,
    output logic signed [DATA_W-1:0]      merged_value,
    output logic                          from_list_b,
    output logic                          last,
    output logic                          overflow_seen
);

    cmd_t    cmd;
    status_t status;

    stwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    stwm_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .value         (value),
        .status        (status),
        .merged_value  (merged_value),
        .from_list_b   (from_list_b),
        .last          (last),
        .overflow_seen (overflow_seen),
        .result_strobe (result_strobe)
    );

endmodule

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_two_way_merge
// Pushes ascending lists into A and B, some with out-of-order values, unused
// request codes, overflowing pushes and full lists. It requests merges and
// checks every strobed result against an in-bench model of the merge.
// ----------------------------------------------------------------------------
module tb;
    import stwm_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam int         RANDOM_ITEMS = 200;
    localparam int         DRAIN_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 200000;

    typedef logic signed [DATA_W-1:0] word_t;

    typedef struct {
        word_t data;
        logic  from_b;
        logic  last;
        logic  ovf;
    } merge_beat_t;

    class merge_scoreboard;
        word_t       list_a[$];
        word_t       list_b[$];
        logic        ovf;
        merge_beat_t beats_q[$];
        int          errors;
        int          n_inputs;
        int          n_merges;
        int          n_beats;
        int          n_drops;

        function new();
            ovf      = 1'b0;
            errors   = 0;
            n_inputs = 0;
            n_merges = 0;
            n_beats  = 0;
            n_drops  = 0;
        endfunction

        function void note_transfer(logic [1:0] req, word_t data);
            int          ia;
            int          ib;
            int          total;
            merge_beat_t beat;
            n_inputs++;
            case (req)
                REQ_PUSH_A:
                begin
                    if (list_a.size() >= LIST_DEPTH)
                    begin
                        ovf = 1'b1;
                        n_drops++;
                    end
                    else
                        list_a.push_back(data);
                end
                REQ_PUSH_B:
                begin
                    if (list_b.size() >= LIST_DEPTH)
                    begin
                        ovf = 1'b1;
                        n_drops++;
                    end
                    else
                        list_b.push_back(data);
                end
                REQ_MERGE:
                begin
                    ia    = 0;
                    ib    = 0;
                    total = list_a.size() + list_b.size();
                    n_merges++;
                    while (ia < list_a.size() || ib < list_b.size())
                    begin
                        if (ib >= list_b.size() ||
                            (ia < list_a.size() && list_a[ia] <= list_b[ib]))
                        begin
                            beat.data   = list_a[ia];
                            beat.from_b = 1'b0;
                            ia++;
                        end
                        else
                        begin
                            beat.data   = list_b[ib];
                            beat.from_b = 1'b1;
                            ib++;
                        end
                        beat.last = (ia + ib == total);
                        beat.ovf  = ovf;
                        beats_q.push_back(beat);
                    end
                    list_a.delete();
                    list_b.delete();
                    ovf = 1'b0;
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_beat(word_t data, logic from_b, logic last, logic ovf_seen);
            merge_beat_t exp_beat;
            if (beats_q.size() == 0)
            begin
                $error("result with nothing expected: merged_value %0d", data);
                errors++;
                return;
            end
            exp_beat = beats_q.pop_front();
            n_beats++;
            if (data !== exp_beat.data)
            begin
                $error("merged_value: expected %0d, actual %0d", exp_beat.data, data);
                errors++;
            end
            if (from_b !== exp_beat.from_b)
            begin
                $error("from_list_b: expected %0b, actual %0b", exp_beat.from_b, from_b);
                errors++;
            end
            if (last !== exp_beat.last)
            begin
                $error("last: expected %0b, actual %0b", exp_beat.last, last);
                errors++;
            end
            if (ovf_seen !== exp_beat.ovf)
            begin
                $error("overflow_seen: expected %0b, actual %0b", exp_beat.ovf, ovf_seen);
                errors++;
            end
        endfunction

        function int pending();
            return beats_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic [1:0] req_type;
    word_t      value;
    logic       result_strobe;
    word_t      merged_value;
    logic       from_list_b;
    logic       last;
    logic       overflow_seen;

    merge_scoreboard sb;
    int              cycle_count;

    sorted_two_way_merge i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .value         (value),
        .result_strobe (result_strobe),
        .merged_value  (merged_value),
        .from_list_b   (from_list_b),
        .last          (last),
        .overflow_seen (overflow_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_strobe === 1'b1)
            sb.check_beat(merged_value, from_list_b, last, overflow_seen);
    end

    // idle share of the sender: 35, then 70, then none
    task automatic idle_gaps();
        int pct;
        pct = (sb.n_inputs < 80) ? 35 : (sb.n_inputs < 160) ? 70 : 0;
        while ($urandom_range(0, 99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send(input logic [1:0] req, input word_t data);
        idle_gaps();
        start    <= 1'b1;
        req_type <= req;
        value    <= data;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_transfer(req, data);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic load_and_merge(input int n_a, input int n_b, input int span);
        longint walk_a;
        longint walk_b;
        longint base;
        int     left_a;
        int     left_b;
        logic   take_a;
        word_t  data;
        case ($urandom_range(0, 3))
            0: base = -64'sd2147483648;
            1: base = 64'sd2147483647 - 4 * longint'(span);
            default: base = longint'(int'($urandom()));
        endcase
        walk_a = base;
        walk_b = base;
        left_a = n_a;
        left_b = n_b;
        while (left_a + left_b > 0)
        begin
            take_a = (left_b == 0) || (left_a > 0 && $urandom_range(0, 1) == 1);
            if (take_a)
            begin
                walk_a = walk_a + $urandom_range(0, span);
                if (walk_a > 64'sd2147483647)
                    walk_a = 64'sd2147483647;
                data = walk_a[DATA_W-1:0];
                left_a--;
            end
            else
            begin
                walk_b = walk_b + $urandom_range(0, span);
                if (walk_b > 64'sd2147483647)
                    walk_b = 64'sd2147483647;
                data = walk_b[DATA_W-1:0];
                left_b--;
            end
            // out-of-order value now and then
            if ($urandom_range(0, 11) == 0)
                data = $urandom();
            send(take_a ? REQ_PUSH_A : REQ_PUSH_B, data);
            if ($urandom_range(0, 24) == 0)
                send(REQ_UNUSED, $urandom());
        end
        send(REQ_MERGE, $urandom());
    endtask

    initial
    begin
        int first;
        int k;
        int n_a;
        int n_b;
        int span;
        sb       = new();
        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = REQ_PUSH_A;
        value    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty merge, unused code, extremes, ties, one-sided lists
        send(REQ_MERGE, 32'sh0000_0000);
        send(REQ_UNUSED, 32'sh8000_0000);
        send(REQ_PUSH_A, 32'sh8000_0000);
        send(REQ_PUSH_A, 32'shFFFF_FFFF);
        send(REQ_PUSH_A, 32'sh0000_0000);
        send(REQ_PUSH_A, 32'sh0000_0005);
        send(REQ_PUSH_A, 32'sh7FFF_FFFF);
        send(REQ_PUSH_B, 32'sh8000_0000);
        send(REQ_PUSH_B, 32'sh0000_0000);
        send(REQ_PUSH_B, 32'sh0000_0005);
        send(REQ_PUSH_B, 32'sh0000_0005);
        send(REQ_PUSH_B, 32'sh7FFF_FFFF);
        send(REQ_MERGE, 32'shFFFF_FFFF);
        send(REQ_PUSH_A, 32'sh0000_0001);
        send(REQ_PUSH_A, 32'sh0000_0002);
        send(REQ_PUSH_A, 32'sh0000_0003);
        send(REQ_MERGE, 32'sh5555_5555);
        send(REQ_PUSH_B, -32'sd7);
        send(REQ_PUSH_B, 32'sd9);
        send(REQ_MERGE, 32'shAAAA_AAAA);
        send(REQ_PUSH_A, 32'sh7FFF_FFFF);
        send(REQ_PUSH_B, 32'sh8000_0000);
        send(REQ_MERGE, 32'sh0000_0000);
        drain();

        first = sb.n_inputs;
        k     = 0;
        while (sb.n_inputs - first < RANDOM_ITEMS)
        begin
            n_a = $urandom_range(0, 6);
            n_b = $urandom_range(0, 6);
            if (k == 2)
            begin
                n_a = LIST_DEPTH + 1;
                n_b = LIST_DEPTH;
            end
            else if (k % 9 == 6)
            begin
                if ($urandom_range(0, 1) == 1)
                    n_a = LIST_DEPTH + $urandom_range(1, 2);
                else
                    n_b = LIST_DEPTH + $urandom_range(1, 2);
            end
            case ($urandom_range(0, 3))
                0: span = 0;
                1: span = 3;
                2: span = 1000;
                default: span = 1 << 26;
            endcase
            load_and_merge(n_a, n_b, span);
            if (k % 5 == 4)
                drain();
            k++;
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Run covered %0d transfers and %0d merge requests.", sb.n_inputs, sb.n_merges);
        $display("Checked %0d merged results; %0d pushes hit a full list.", sb.n_beats,
                 sb.n_drops);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
